// ===== rtl/core/sv48ptw_pkg.sv =====
// shared types and constants of the sv48 page table walker
package sv48ptw_pkg;

   localparam int VA_W        = 48;
   localparam int PTE_W       = 64;
   localparam int PA_W        = 64;
   localparam int PPN_W       = 52;
   localparam int IDX_W       = 9;
   localparam int PAGE_OFF_W  = 12;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 4;
   localparam int QUEUE_DEPTH = 4;

   // entry flag positions
   localparam int PTE_V_BIT   = 0;
   localparam int PTE_R_BIT   = 1;
   localparam int PTE_X_BIT   = 3;
   localparam int PTE_PPN_LSB = 10;

   // register index, decoded from paddr[3]
   localparam logic REG_ROOT_PAGE = 1'b0;

   localparam logic [1:0] LEVEL_TOP = 2'd3;
   localparam logic [1:0] LEVEL_LAST = 2'd0;

   typedef enum logic {
      FUNC_TRANSLATE = 1'b0,
      FUNC_RESPONSE  = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      KIND_READ    = 2'd0,
      KIND_DONE    = 2'd1,
      KIND_FAULT   = 2'd2,
      KIND_IGNORED = 2'd3
   } kind_type;

   typedef struct packed {
      func_type              func;
      logic [VA_W-1:0]       vaddr;
      logic [PTE_W-1:0]      pte_word;
   } req_item_type;

   typedef struct packed {
      kind_type              result_kind;
      logic [PA_W-1:0]       entry_addr;
      logic [PA_W-1:0]       phys_addr;
      logic [1:0]            walk_level;
   } rsp_item_type;

   // classified item as held in the queue
   typedef struct packed {
      func_type              func;
      logic [VA_W-1:0]       vaddr;
      logic                  pte_v;
      logic                  pte_leaf;
      logic [PPN_W-1:0]      next_ppn;
   } walk_op_type;

   // queue status seen by the front and back
   typedef struct packed {
      logic                  full;
      logic                  empty;
   } queue_status_type;

endpackage

// ===== rtl/core/sv48_page_table_walker.sv =====
// top level of the sv48 four-level page table walker
//
// channel  direction  handshake                 payload
// req      in         req_valid / req_stall     req_item  (func, vaddr, pte_word)
// rsp      out        rsp_valid / rsp_stall     rsp_item  (kind, entry/phys addr, level)
// csr      in         csr_psel/penable/pwrite   root_page at byte address 0, 52 of 64 bits
//
// every item is handled in a single pass: front classifies and pushes into the queue,
// back pops one item a cycle into the result register, so one item per cycle
// sustained while rsp does not stall; results pass the queue, then the result register
// reset is synchronous and clears walk state, queue pointers and root_page
// req_stall rises only when the queue is full; a stalled rsp holds the result
// register and the queue soaks up to QUEUE_DEPTH_P further items meanwhile
module sv48_page_table_walker
   import sv48ptw_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
   input  logic                  clock,
   input  logic                  reset,
   // request items
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_item_type          req_item,
   // result items
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_item_type          rsp_item,
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [PPN_W-1:0]  root_ff, root_in;
   logic              csr_wr;
   queue_status_type  q_status;
   logic              push_valid;
   walk_op_type       push_op;
   logic              pop_take;
   walk_op_type       pop_op;

   // register port: zero wait states, one register holding a 52-bit root page number
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      root_in = root_ff;
      if (csr_wr && csr_paddr[3] == REG_ROOT_PAGE) begin
         root_in = csr_pwdata[PPN_W-1:0];
      end
   end

   // reads of unmapped addresses return zero
   assign csr_prdata = (csr_paddr[3] == REG_ROOT_PAGE)
                       ? {{(CSR_DATA_W-PPN_W){1'b0}}, root_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff <= '0;
      end else begin
         root_ff <= root_in;
      end
   end

   // front: accept and classify
   sv48ptw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .q_status   (q_status),
      .push_valid (push_valid),
      .push_op    (push_op)
   );

   // decoupling queue
   sv48ptw_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_op    (push_op),
      .pop_take   (pop_take),
      .pop_op     (pop_op),
      .q_status   (q_status)
   );

   // back: walk state machine and result register
   sv48ptw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .root_page (root_ff),
      .q_status  (q_status),
      .pop_op    (pop_op),
      .pop_take  (pop_take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

// ===== rtl/core/sv48ptw_front.sv =====
// front end: takes input items and classifies them for the walk engine
module sv48ptw_front
   import sv48ptw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_item_type     req_item,
   input  queue_status_type q_status,
   output logic             push_valid,
   output walk_op_type      push_op
);

   always_comb begin
      push_op.func     = req_item.func;
      push_op.vaddr    = req_item.vaddr;
      push_op.pte_v    = req_item.pte_word[PTE_V_BIT];
      // leaf entry when r or x is set
      push_op.pte_leaf = req_item.pte_word[PTE_R_BIT] | req_item.pte_word[PTE_X_BIT];
      // page number field, bits 61:10; bits 62 and 63 drop out
      push_op.next_ppn = req_item.pte_word[PTE_PPN_LSB +: PPN_W];
   end

   assign req_stall  = q_status.full;
   assign push_valid = req_valid && !q_status.full;

   assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !push_valid)
      else $error("push while queue full");

   assert property (@(posedge clock) disable iff (reset)
      push_valid |-> push_op.next_ppn == req_item.pte_word[61:10])
      else $error("page number field misaligned");

   assert property (@(posedge clock) disable iff (reset)
      !q_status.full |-> req_stall == 1'b0)
      else $error("stall without full queue");

endmodule

// ===== rtl/core/sv48ptw_queue.sv =====
// short queue of classified items between front and back
module sv48ptw_queue
   import sv48ptw_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  walk_op_type      push_op,
   input  logic             pop_take,
   output walk_op_type      pop_op,
   output queue_status_type q_status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   walk_op_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   do_push, do_pop;

   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push = push_valid && !q_status.full;
   assign do_pop  = pop_take && !q_status.empty;
   assign pop_op  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count lost a push");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with pointers apart");

endmodule

// ===== rtl/core/sv48ptw_back.sv =====
// back end: walk state and registered result
module sv48ptw_back
   import sv48ptw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [PPN_W-1:0] root_page,
   input  queue_status_type q_status,
   input  walk_op_type      pop_op,
   output logic             pop_take,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_item_type     rsp_item
);

   logic              busy_ff, busy_in;
   logic [1:0]        level_ff, level_in;
   logic [VA_W-1:0]   saved_va_ff, saved_va_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_item_ff, rsp_item_in;
   logic [1:0]        next_lvl;
   logic [PA_W-1:0]   low_mask;
   logic [PA_W-1:0]   leaf_base;

   assign pop_take  = !q_status.empty && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
   assign next_lvl  = level_ff - 1'b1;
   assign leaf_base = {pop_op.next_ppn, {PAGE_OFF_W{1'b0}}};

   always_comb begin
      case (level_ff)
         2'd0:    low_mask = {{(PA_W-12){1'b0}}, {12{1'b1}}};
         2'd1:    low_mask = {{(PA_W-21){1'b0}}, {21{1'b1}}};
         2'd2:    low_mask = {{(PA_W-30){1'b0}}, {30{1'b1}}};
         default: low_mask = {{(PA_W-39){1'b0}}, {39{1'b1}}};
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      level_in     = level_ff;
      saved_va_in  = saved_va_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;
      if (pop_take) begin
         rsp_valid_in            = 1'b1;
         rsp_item_in.result_kind = KIND_IGNORED;
         rsp_item_in.entry_addr  = '0;
         rsp_item_in.phys_addr   = '0;
         rsp_item_in.walk_level  = level_ff;
         if (pop_op.func == FUNC_TRANSLATE) begin
            if (!busy_ff) begin
               busy_in                 = 1'b1;
               level_in                = LEVEL_TOP;
               saved_va_in             = pop_op.vaddr;
               rsp_item_in.result_kind = KIND_READ;
               rsp_item_in.entry_addr  = {root_page, pop_op.vaddr[47:39], 3'b000};
               rsp_item_in.walk_level  = LEVEL_TOP;
            end
         end else if (busy_ff) begin
            if (!pop_op.pte_v) begin
               busy_in                 = 1'b0;
               level_in                = LEVEL_TOP;
               rsp_item_in.result_kind = KIND_FAULT;
            end else if (level_ff == LEVEL_LAST || pop_op.pte_leaf) begin
               busy_in                 = 1'b0;
               level_in                = LEVEL_TOP;
               rsp_item_in.result_kind = KIND_DONE;
               rsp_item_in.phys_addr   = leaf_base
                                         | ({{(PA_W-VA_W){1'b0}}, saved_va_ff} & low_mask);
            end else begin
               level_in                = next_lvl;
               rsp_item_in.result_kind = KIND_READ;
               rsp_item_in.walk_level  = next_lvl;
               rsp_item_in.entry_addr  = {pop_op.next_ppn,
                                          saved_va_ff[PAGE_OFF_W + IDX_W*next_lvl +: IDX_W],
                                          3'b000};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         level_ff     <= LEVEL_TOP;
         saved_va_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         level_ff     <= level_in;
         saved_va_ff  <= saved_va_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> level_ff == LEVEL_TOP)
      else $error("idle walker not at top level");

   assert property (@(posedge clock) disable iff (reset)
      (pop_take && !busy_ff && pop_op.func == FUNC_TRANSLATE)
      |=> rsp_valid_ff && rsp_item_ff.result_kind == KIND_READ
          && rsp_item_ff.walk_level == LEVEL_TOP && busy_ff)
      else $error("walk start did not issue top read");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.result_kind != KIND_READ) |-> rsp_item_ff.entry_addr == '0)
      else $error("entry address on non-read result");

   assert property (@(posedge clock) disable iff (reset)
      (pop_take && busy_ff && pop_op.func == FUNC_RESPONSE && !pop_op.pte_v) |=> !busy_ff)
      else $error("fault did not end walk");

endmodule
